// ----- hw/rtl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the source token scanner
// event descriptors, queue entry layout, result kind codes, queue depth
// ----------------------------------------------------------------------------
package sts_pkg;

  // result kind codes
  localparam logic [2:0] KIND_SPECIAL  = 3'd0;
  localparam logic [2:0] KIND_STRING   = 3'd1;
  localparam logic [2:0] KIND_NAME     = 3'd2;
  localparam logic [2:0] KIND_END      = 3'd3;
  localparam logic [2:0] KIND_ILLEGAL  = 3'd4;
  localparam logic [2:0] KIND_UNCLOSED = 3'd5;

  // most results one source byte can cause
  localparam int unsigned MAX_EVENTS = 3;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic       has_char;
    logic       tok_start;
    logic       tok_end;
  } sts_event_t;

  // all events with a character carry the same source byte
  typedef struct packed {
    logic [7:0]                  ch;
    logic [1:0]                  count;  // 1 to 3 events
    sts_event_t [MAX_EVENTS-1:0] ev;     // ev[0] goes out first
  } sts_entry_t;

endpackage

// ----- hw/rtl/sts_front.sv -----
// ----------------------------------------------------------------------------
// sts_front: byte classifier and scan state
// classifies each accepted byte, updates the scan mode and builds the list
// of token events the byte causes as one queue entry
// ----------------------------------------------------------------------------
module sts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         byte_value,
  input  logic               final_byte,
  output logic               push,
  output sts_pkg::sts_entry_t entry
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NAME = 2'd1;
  localparam logic [1:0] MODE_STR  = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  logic [1:0] mode_r, mode_nxt;
  logic       quote_r, quote_nxt;

  logic       c_space, c_special, c_quote, c_start, c_name;
  logic       idle_v;
  sts_pkg::sts_event_t idle_ev;
  logic [1:0] idle_mode;
  logic       idle_quote;
  logic [7:0] close_q;

  sts_pkg::sts_event_t ev_all [0:3];
  logic [2:0] cnt;
  logic [1:0] mode_mid;

  always_comb begin
    c_space   = (byte_value == CH_SPACE) || (byte_value == CH_LF) ||
                (byte_value == CH_CR) || (byte_value == CH_TAB);
    c_special = (byte_value == CH_LPAREN) || (byte_value == CH_RPAREN) ||
                (byte_value == CH_LBRACE) || (byte_value == CH_RBRACE) ||
                (byte_value == CH_COMMA) || (byte_value == CH_SEMI) ||
                (byte_value == CH_EQUAL) || (byte_value == CH_COLON);
    c_quote   = (byte_value == CH_DQUOTE) || (byte_value == CH_SQUOTE);
    c_start   = (byte_value >= 8'h61 && byte_value <= 8'h7A) ||
                (byte_value >= 8'h41 && byte_value <= 8'h5A) ||
                (byte_value == CH_UNDER);
    c_name    = c_start || (byte_value >= 8'h30 && byte_value <= 8'h39);
    close_q   = quote_r ? CH_SQUOTE : CH_DQUOTE;
  end

  // what a byte does between tokens
  always_comb begin
    idle_v     = 1'b1;
    idle_ev    = '{kind: sts_pkg::KIND_ILLEGAL, has_char: 1'b0,
                   tok_start: 1'b0, tok_end: 1'b0};
    idle_mode  = MODE_DROP;
    idle_quote = quote_r;
    priority if (c_space) begin
      idle_v    = 1'b0;
      idle_mode = MODE_IDLE;
    end else if (c_special) begin
      idle_ev   = '{kind: sts_pkg::KIND_SPECIAL, has_char: 1'b1,
                    tok_start: 1'b1, tok_end: 1'b1};
      idle_mode = MODE_IDLE;
    end else if (c_quote) begin
      idle_ev    = '{kind: sts_pkg::KIND_STRING, has_char: 1'b0,
                     tok_start: 1'b1, tok_end: 1'b0};
      idle_mode  = MODE_STR;
      idle_quote = (byte_value == CH_SQUOTE);
    end else if (c_start) begin
      idle_ev   = '{kind: sts_pkg::KIND_NAME, has_char: 1'b1,
                    tok_start: 1'b1, tok_end: 1'b0};
      idle_mode = MODE_NAME;
    end
  end

  // event list of this byte; at most three survive
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ev_all[i] = '0;
    end
    cnt       = 3'd0;
    mode_mid  = mode_r;
    quote_nxt = quote_r;
    unique case (mode_r)
      MODE_IDLE: begin
        if (idle_v) begin
          ev_all[cnt[1:0]] = idle_ev;
          cnt = cnt + 3'd1;
        end
        mode_mid  = idle_mode;
        quote_nxt = idle_quote;
      end
      MODE_NAME: begin
        if (c_name) begin
          ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_NAME, has_char: 1'b1,
                               tok_start: 1'b0, tok_end: 1'b0};
          cnt = cnt + 3'd1;
        end else begin
          // name closes, the byte is then taken as between tokens
          ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_NAME, has_char: 1'b0,
                               tok_start: 1'b0, tok_end: 1'b1};
          cnt = cnt + 3'd1;
          if (idle_v) begin
            ev_all[cnt[1:0]] = idle_ev;
            cnt = cnt + 3'd1;
          end
          mode_mid  = idle_mode;
          quote_nxt = idle_quote;
        end
      end
      MODE_STR: begin
        if (byte_value == close_q) begin
          ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_STRING, has_char: 1'b0,
                               tok_start: 1'b0, tok_end: 1'b1};
          mode_mid = MODE_IDLE;
        end else begin
          ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_STRING, has_char: 1'b1,
                               tok_start: 1'b0, tok_end: 1'b0};
        end
        cnt = cnt + 3'd1;
      end
      default: begin
        // dropping after an error
      end
    endcase
    mode_nxt = mode_mid;
    if (final_byte) begin
      if (mode_mid == MODE_NAME) begin
        ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_NAME, has_char: 1'b0,
                             tok_start: 1'b0, tok_end: 1'b1};
        cnt = cnt + 3'd1;
      end else if (mode_mid == MODE_STR) begin
        ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_UNCLOSED, has_char: 1'b0,
                             tok_start: 1'b0, tok_end: 1'b0};
        cnt = cnt + 3'd1;
      end
      // a fourth event (end token) is cut off
      if (cnt != 3'd4 && cnt != 3'd3) begin
        ev_all[cnt[1:0]] = '{kind: sts_pkg::KIND_END, has_char: 1'b0,
                             tok_start: 1'b1, tok_end: 1'b1};
      end
      cnt       = cnt + 3'd1;
      mode_nxt  = MODE_IDLE;
      quote_nxt = 1'b0;
    end
  end

  always_comb begin
    entry.ch    = byte_value;
    entry.count = cnt[2] ? 2'd3 : cnt[1:0];
    entry.ev[0] = ev_all[0];
    entry.ev[1] = ev_all[1];
    entry.ev[2] = ev_all[2];
    push        = accept && (cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      quote_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
    end
  end

endmodule

// ----- hw/rtl/sts_queue.sv -----
// ----------------------------------------------------------------------------
// sts_queue: short event queue between front and back
// register based fifo of queue entries, head shown combinationally
// ----------------------------------------------------------------------------
module sts_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sts_pkg::sts_entry_t push_data,
  input  logic                pop,
  output sts_pkg::sts_entry_t head,
  output logic                empty,
  output logic                full
);

  sts_pkg::sts_entry_t slots_r [0:sts_pkg::QUEUE_DEPTH-1];
  logic [sts_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sts_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == sts_pkg::QCNT_W'(sts_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == sts_pkg::QPTR_W'(sts_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == sts_pkg::QPTR_W'(sts_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/sts_back.sv -----
// ----------------------------------------------------------------------------
// sts_back: event sequencer and output register
// walks the events of the head entry, one result per cycle while the output
// is not stalled, into the output register
// ----------------------------------------------------------------------------
module sts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sts_pkg::sts_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          char_out,
  output sts_pkg::sts_event_t out_ev,
  output logic                last_of_run
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] char_r;
  sts_pkg::sts_event_t ev_r;
  logic       last_r;

  logic load;
  logic is_last;
  sts_pkg::sts_event_t cur_ev;

  assign load    = !empty && (!valid_r || out_ready);
  assign cur_ev  = head.ev[idx_r];
  assign is_last = (idx_r == head.count - 2'd1);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= cur_ev;
      char_r <= cur_ev.has_char ? head.ch : 8'd0;
      last_r <= is_last;
    end
  end

  assign out_valid   = valid_r;
  assign char_out    = char_r;
  assign out_ev      = ev_r;
  assign last_of_run = last_r;

endmodule

// ----- hw/rtl/source_token_scanner.sv -----
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexical scanner for source bytes
// turns a byte stream into special, string, name, end and error events
// ----------------------------------------------------------------------------
// The scanner takes one source byte per cycle while its queue is not full
// (tlast marks the last byte of a buffer) and gives zero to three token
// events for it. Plain text with one event or none per byte streams at one
// byte per clock while the output keeps up; the back sequencer sends one
// event per cycle while the output is not stalled. The front classifies the
// byte and keeps the scan state in the same cycle it is taken; a four-entry
// queue lets the front keep accepting while the output is stalled. The first
// event of a byte is written to a queue slot, then loaded into the output
// register. Each buffer restarts between tokens after its end token.
// ----------------------------------------------------------------------------
module source_token_scanner (
  input  logic       clk,
  input  logic       rst_n,
  // input transactions
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tlast,   // final_byte
  // result transactions
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic [5:0] out_tuser,  // [2:0] kind, [3] has_char, [4] token_start,
                                 // [5] token_end
  output logic       out_tlast   // last_of_run
);

  logic                accept;
  logic                push;
  sts_pkg::sts_entry_t entry;
  sts_pkg::sts_entry_t head;
  logic                q_empty, q_full;
  logic                pop;
  sts_pkg::sts_event_t out_ev;

  // front waits only on a full queue
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // classifier and scan state
  sts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_tdata),
    .final_byte (in_tlast),
    .push       (push),
    .entry      (entry)
  );

  // decoupling queue
  sts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // event sequencer with output register
  sts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .char_out    (out_tdata),
    .out_ev      (out_ev),
    .last_of_run (out_tlast)
  );

  assign out_tuser = {out_ev.tok_end, out_ev.tok_start, out_ev.has_char, out_ev.kind};

endmodule

// ----- hw/rtl/sts_checker.sv -----
// ----------------------------------------------------------------------------
// sts_checker: port level checks of the source token scanner
// result stability and consistency of event fields
// ----------------------------------------------------------------------------
module sts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [5:0] out_tuser,
  input logic       out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // no character byte without has_char
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[3] |-> out_tdata == 8'd0)
    else $error("char_out set without has_char");

  // end token is a whole token, always the last result of its byte
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == sts_pkg::KIND_END |->
      out_tlast && out_tuser[4] && out_tuser[5] && !out_tuser[3])
    else $error("malformed end token");

  // error events carry no flags
  a_error_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == sts_pkg::KIND_ILLEGAL ||
                   out_tuser[2:0] == sts_pkg::KIND_UNCLOSED) |->
      out_tuser[5:3] == 3'b000)
    else $error("error event with flags");

  // kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:0] != 3'd6 && out_tuser[2:0] != 3'd7)
    else $error("undefined result kind");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/tb_source_token_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_token_scanner: self-checking bench for the source token scanner
// a directed pass over punctuation, blanks, names, strings and the buffer-end
// corner cases, then random buffers of mostly well-formed tokens mixed with
// noise and cut-off buffers; a scoreboard class predicts every token event
// and checks each output transaction in order, while the sender idles in
// bursts and the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
module tb_source_token_scanner;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_CYCLES = 16;

  // scan state of the predictor
  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_NAME   = 2'd1,
    SCAN_STRING = 2'd2,
    SCAN_DROP   = 2'd3
  } scan_mode_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       has_char;
    logic       tok_start;
    logic       tok_end;
    logic       last_run;
  } token_ev_t;

  // predicts the token events of each accepted byte and checks them in order
  class token_event_checker;
    token_ev_t  expected_events[$];
    token_ev_t  byte_events[$];
    scan_mode_t mode;
    bit         single_q;
    int         fail_count;

    function new();
      mode       = SCAN_IDLE;
      single_q   = 1'b0;
      fail_count = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
    endfunction

    function bit is_punct(logic [7:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}" ||
             c == "," || c == ";" || c == "=" || c == ":";
    endfunction

    function bit is_ident_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_ident_char(logic [7:0] c);
      return is_ident_start(c) || (c >= "0" && c <= "9");
    endfunction

    // one byte never gives more than three events, later ones are lost
    function void add_event(logic [2:0] kind, logic [7:0] ch, bit has, bit st, bit en);
      token_ev_t ev;
      if (byte_events.size() >= sts_pkg::MAX_EVENTS) return;
      ev.kind      = kind;
      ev.ch        = has ? ch : 8'h00;
      ev.has_char  = has;
      ev.tok_start = st;
      ev.tok_end   = en;
      ev.last_run  = 1'b0;
      byte_events.push_back(ev);
    endfunction

    // a byte seen between tokens
    function void start_token(logic [7:0] c);
      if (is_blank(c)) return;
      if (is_punct(c)) begin
        add_event(sts_pkg::KIND_SPECIAL, c, 1'b1, 1'b1, 1'b1);
      end else if (c == "\"" || c == "'") begin
        single_q = (c == "'");
        mode     = SCAN_STRING;
        add_event(sts_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
      end else if (is_ident_start(c)) begin
        mode = SCAN_NAME;
        add_event(sts_pkg::KIND_NAME, c, 1'b1, 1'b1, 1'b0);
      end else begin
        mode = SCAN_DROP;
        add_event(sts_pkg::KIND_ILLEGAL, 8'h00, 1'b0, 1'b0, 1'b0);
      end
    endfunction

    function void note_input(logic [7:0] c, bit fin);
      logic [7:0] close_q;
      byte_events.delete();
      case (mode)
        SCAN_IDLE: begin
          start_token(c);
        end
        SCAN_NAME: begin
          if (is_ident_char(c)) begin
            add_event(sts_pkg::KIND_NAME, c, 1'b1, 1'b0, 1'b0);
          end else begin
            // the byte that ends a name is scanned on its own
            add_event(sts_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1);
            mode = SCAN_IDLE;
            start_token(c);
          end
        end
        SCAN_STRING: begin
          close_q = single_q ? "'" : "\"";
          if (c == close_q) begin
            add_event(sts_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1);
            mode = SCAN_IDLE;
          end else begin
            add_event(sts_pkg::KIND_STRING, c, 1'b1, 1'b0, 1'b0);
          end
        end
        default: ;
      endcase
      if (fin) begin
        if (mode == SCAN_NAME)
          add_event(sts_pkg::KIND_NAME, 8'h00, 1'b0, 1'b0, 1'b1);
        else if (mode == SCAN_STRING)
          add_event(sts_pkg::KIND_UNCLOSED, 8'h00, 1'b0, 1'b0, 1'b0);
        add_event(sts_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
        mode     = SCAN_IDLE;
        single_q = 1'b0;
      end
      if (byte_events.size() > 0) byte_events[byte_events.size()-1].last_run = 1'b1;
      foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
    endfunction

    function void check_result(token_ev_t got);
      token_ev_t want;
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind %0d char %h has %0b start %0b end %0b last %0b",
                   got.kind, got.ch, got.has_char, got.tok_start, got.tok_end, got.last_run);
        return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch || got.has_char !== want.has_char ||
          got.tok_start !== want.tok_start || got.tok_end !== want.tok_end ||
          got.last_run !== want.last_run) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected kind %0d char %h has %0b start %0b end %0b last %0b",
                   want.kind, want.ch, want.has_char, want.tok_start, want.tok_end,
                   want.last_run);
          $display("          actual   kind %0d char %h has %0b start %0b end %0b last %0b",
                   got.kind, got.ch, got.has_char, got.tok_start, got.tok_end, got.last_run);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] byte_value
  logic       in_tlast;   // final_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] char_out
  logic [5:0] out_tuser;  // [2:0] kind, [3] has_char, [4] token_start, [5] token_end
  logic       out_tlast;  // last_of_run

  token_event_checker tok_chk;

  int cycle_cnt;
  int items_sent;
  int burst_left;

  // receiver stall pattern state
  int          rx_tick;
  int          rx_mode;
  logic [15:0] rx_pattern;

  source_token_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: periodically picks free running, a random mask, or heavy stall
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) begin
      rx_mode    = $urandom_range(0, 2);
      rx_pattern = $urandom;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= rx_pattern[rx_tick % 16];
      default: out_tready <= (rx_tick % 4 == 0);
    endcase
  end

  // output monitor, samples the transaction at the edge it completes
  always @(posedge clk) begin
    token_ev_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind      = out_tuser[2:0];
      got.has_char  = out_tuser[3];
      got.tok_start = out_tuser[4];
      got.tok_end   = out_tuser[5];
      got.ch        = out_tdata;
      got.last_run  = out_tlast;
      tok_chk.check_result(got);
    end
  end

  // one input transaction; valid stays high across a burst
  task automatic send_byte(logic [7:0] b, bit fin);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tok_chk.note_input(b, fin);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch without gaps
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [7:0] pick_ident_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // one buffer: mostly well-formed tokens, some noise and cut-off buffers
  task automatic send_random_buffer();
    logic [7:0] bytes[$];
    logic [7:0] punct_set[8];
    logic [7:0] blank_set[4];
    logic [7:0] c;
    logic [7:0] qc;
    int         r;
    int         len;
    punct_set = '{"(", ")", "{", "}", ",", ";", "=", ":"};
    blank_set = '{8'h20, 8'h09, 8'h0A, 8'h0D};
    r = $urandom_range(0, 99);
    if (r < 12) begin
      len = $urandom_range(1, 8);
      repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: bytes.push_back(punct_set[$urandom_range(0, 7)]);
          1: begin
            bytes.push_back(pick_ident_char(1'b1));
            repeat ($urandom_range(0, 5)) bytes.push_back(pick_ident_char(1'b0));
            if ($urandom_range(0, 1)) bytes.push_back(blank_set[$urandom_range(0, 3)]);
          end
          2: begin
            qc = $urandom_range(0, 1) ? "'" : "\"";
            bytes.push_back(qc);
            repeat ($urandom_range(0, 5)) begin
              c = 8'($urandom_range(0, 255));
              if (c == qc) c = c ^ 8'h01;
              bytes.push_back(c);
            end
            bytes.push_back(qc);
          end
          default: repeat ($urandom_range(1, 3)) bytes.push_back(blank_set[$urandom_range(0, 3)]);
        endcase
      end
      // cut-off buffer: ends anywhere, often inside a name or a string
      if (r < 24) begin
        len = $urandom_range(1, bytes.size());
        while (bytes.size() > len) void'(bytes.pop_back());
      end else if ($urandom_range(0, 1)) begin
        bytes.push_back(blank_set[$urandom_range(0, 3)]);
      end
    end
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  initial begin
    string puncts;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cycle_cnt  = 0;
    items_sent = 0;
    burst_left = 4;
    rx_tick    = 0;
    rx_mode    = 0;
    rx_pattern = 16'hFFFF;
    tok_chk    = new();
    puncts     = "(){},;=:";

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every punctuation byte and every blank
    for (int i = 0; i < puncts.len(); i++) send_byte(puncts[i], 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h0D, 1'b0);
    // name closed by an opening quote; the other quote and 0xff inside
    send_byte("_", 1'b0);
    send_byte("a", 1'b0);
    send_byte("Z", 1'b0);
    send_byte("9", 1'b0);
    send_byte("'", 1'b0);
    send_byte("\"", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("'", 1'b0);
    // buffer ends inside a string
    send_byte("\"", 1'b0);
    send_byte(8'h00, 1'b1);
    // buffer ends inside a name
    send_byte("q", 1'b1);
    // name close, string open, unclosed string: end token is crowded out
    send_byte("x", 1'b0);
    send_byte("\"", 1'b1);
    // illegal character, then dropping until the end of the buffer
    send_byte("@", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte("(", 1'b1);
    send_byte(8'h00, 1'b1);

    while (items_sent < RANDOM_ITEMS) send_random_buffer();

    in_tvalid <= 1'b0;
    while (tok_chk.expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tok_chk.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sts_pkg.sv
hw/rtl/sts_front.sv
hw/rtl/sts_queue.sv
hw/rtl/sts_back.sv
hw/rtl/source_token_scanner.sv
hw/rtl/sts_checker.sv
dv/tb_source_token_scanner.sv
